>>> design/cld_pkg.sv
`timescale 1ns / 1ps

package cld_pkg;

  localparam int unsigned TIME_BITS_DEF = 31;
  localparam int unsigned HYST_DEF      = 30;

  localparam int unsigned DT_W    = 16;
  localparam int unsigned LEVEL_W = 7;
  localparam int unsigned SECS_W  = 31;
  localparam int unsigned CFG_W   = 31;
  localparam int unsigned CFG_A_W = 3;
  localparam int unsigned STATE_W = 3;

  // state codes
  localparam logic [STATE_W-1:0] ST_INIT         = 3'd0;
  localparam logic [STATE_W-1:0] ST_DISABLED     = 3'd1;
  localparam logic [STATE_W-1:0] ST_DISCONNECTED = 3'd2;
  localparam logic [STATE_W-1:0] ST_CONNECTED    = 3'd3;
  localparam logic [STATE_W-1:0] ST_ACTIVE       = 3'd4;

  // register indexes
  localparam logic [CFG_A_W-1:0] CFG_ACTIVATE_AFTER = 3'd0;
  localparam logic [CFG_A_W-1:0] CFG_CLEAR_AFTER    = 3'd1;
  localparam logic [CFG_A_W-1:0] CFG_FULL_CAPACITY  = 3'd2;
  localparam logic [CFG_A_W-1:0] CFG_DEF_START      = 3'd3;
  localparam logic [CFG_A_W-1:0] CFG_DEF_STOP       = 3'd4;
  localparam logic [CFG_A_W-1:0] CFG_DEFAULT_START  = 3'd5;
  localparam logic [CFG_A_W-1:0] CFG_DEFAULT_STOP   = 3'd6;

  // register reset values
  localparam logic [CFG_W-1:0]   RST_ACTIVATE_AFTER = 31'd14400;
  localparam logic [CFG_W-1:0]   RST_CLEAR_AFTER    = 31'd60;
  localparam logic [LEVEL_W-1:0] RST_FULL_CAPACITY  = 7'd100;
  localparam logic [LEVEL_W-1:0] RST_DEF_START      = 7'd70;
  localparam logic [LEVEL_W-1:0] RST_DEF_STOP       = 7'd80;
  localparam logic [LEVEL_W-1:0] RST_DEFAULT_START  = 7'd0;
  localparam logic [LEVEL_W-1:0] RST_DEFAULT_STOP   = 7'd100;

  localparam logic [CFG_W-1:0]   MIN_ACTIVATE = 31'd60;

endpackage

>>> design/charge_limit_defender_fsm.sv
`timescale 1ns / 1ps
// throughput: one request per cycle unless out_ready stalls; an input register feeds
// one pass of state logic into the result register, which drives out_valid, and the
// state updates as the result is loaded
// reset (synchronous, rst_n low): state init, counters and persist history cleared,
// registers at their default values, both channels empty

module charge_limit_defender_fsm
  import cld_pkg::*;
#(
  parameter int unsigned TIME_BITS          = TIME_BITS_DEF,
  parameter int unsigned PERSIST_HYSTERESIS = HYST_DEF
) (
  input  logic               clk,
  input  logic               rst_n,

  input  logic               cfg_we,
  input  logic [CFG_A_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]   cfg_wdata,

  input  logic               in_valid,
  output logic               in_ready,
  input  logic [DT_W-1:0]    in_elapsed_secs,
  input  logic               in_wired_present,
  input  logic               in_wireless_online,
  input  logic [LEVEL_W-1:0] in_capacity_pct,
  input  logic [LEVEL_W-1:0] in_vendor_start,
  input  logic [LEVEL_W-1:0] in_vendor_stop,
  input  logic               in_disable_request,
  input  logic               in_debug_build,
  input  logic               in_charger_boot,
  input  logic [SECS_W-1:0]  in_saved_present_secs,
  input  logic [SECS_W-1:0]  in_saved_active_secs,

  output logic               out_valid,
  input  logic               out_ready,
  output logic [STATE_W-1:0] out_fsm_state,
  output logic [LEVEL_W-1:0] out_start_level,
  output logic [LEVEL_W-1:0] out_stop_level,
  output logic               out_start_write,
  output logic               out_stop_write,
  output logic [SECS_W-1:0]  out_present_secs,
  output logic [SECS_W-1:0]  out_active_secs,
  output logic               out_present_persist,
  output logic               out_active_persist
);

  localparam int unsigned CW = ((TIME_BITS > SECS_W) ? TIME_BITS : SECS_W) + 1;
  localparam logic [TIME_BITS-1:0] TMAX = '1;

  // config registers
  logic [CFG_W-1:0]   act_after_r;
  logic [CFG_W-1:0]   clr_after_r;
  logic [LEVEL_W-1:0] full_cap_r;
  logic [LEVEL_W-1:0] def_start_r;
  logic [LEVEL_W-1:0] def_stop_r;
  logic [LEVEL_W-1:0] dflt_start_r;
  logic [LEVEL_W-1:0] dflt_stop_r;

  // input register
  logic               s1_valid_r;
  logic [DT_W-1:0]    s1_dt_r;
  logic               s1_power_r;
  logic [LEVEL_W-1:0] s1_cap_r;
  logic [LEVEL_W-1:0] s1_vstart_r;
  logic [LEVEL_W-1:0] s1_vstop_r;
  logic               s1_dis_r;
  logic               s1_debug_r;
  logic               s1_boot_r;
  logic [SECS_W-1:0]  s1_sp_r;
  logic [SECS_W-1:0]  s1_sa_r;

  // block state
  logic [STATE_W-1:0]   state_r;
  logic [STATE_W-1:0]   state_nxt;
  logic                 high_r;
  logic                 high_nxt;
  logic [TIME_BITS-1:0] present_r;
  logic [TIME_BITS-1:0] present_nxt;
  logic [TIME_BITS-1:0] absent_r;
  logic [TIME_BITS-1:0] absent_nxt;
  logic [TIME_BITS-1:0] active_r;
  logic [TIME_BITS-1:0] active_nxt;
  logic [LEVEL_W-1:0]   last_start_r;
  logic [LEVEL_W-1:0]   last_stop_r;

  logic               advance;
  logic               disabled;
  logic [CW-1:0]      act_th;
  logic [LEVEL_W-1:0] lstart;
  logic [LEVEL_W-1:0] lstop;
  logic               wstart;
  logic               wstop;
  logic               pp;
  logic               ap;

  function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                   input logic [DT_W-1:0] b);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + (TIME_BITS+1)'(b);
    return s[TIME_BITS] ? TMAX : s[TIME_BITS-1:0];
  endfunction

  function automatic logic [TIME_BITS-1:0] sat_load(input logic [SECS_W-1:0] v);
    return (CW'(v) > CW'(TMAX)) ? TMAX : TIME_BITS'(v);
  endfunction

  assign advance  = s1_valid_r && (!out_valid || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_after_r  <= RST_ACTIVATE_AFTER;
      clr_after_r  <= RST_CLEAR_AFTER;
      full_cap_r   <= RST_FULL_CAPACITY;
      def_start_r  <= RST_DEF_START;
      def_stop_r   <= RST_DEF_STOP;
      dflt_start_r <= RST_DEFAULT_START;
      dflt_stop_r  <= RST_DEFAULT_STOP;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_ACTIVATE_AFTER: act_after_r  <= cfg_wdata;
        CFG_CLEAR_AFTER:    clr_after_r  <= cfg_wdata;
        CFG_FULL_CAPACITY:  full_cap_r   <= cfg_wdata[LEVEL_W-1:0];
        CFG_DEF_START:      def_start_r  <= cfg_wdata[LEVEL_W-1:0];
        CFG_DEF_STOP:       def_stop_r   <= cfg_wdata[LEVEL_W-1:0];
        CFG_DEFAULT_START:  dflt_start_r <= cfg_wdata[LEVEL_W-1:0];
        CFG_DEFAULT_STOP:   dflt_stop_r  <= cfg_wdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_dt_r     <= in_elapsed_secs;
      s1_power_r  <= in_wired_present || in_wireless_online;
      s1_cap_r    <= in_capacity_pct;
      s1_vstart_r <= in_vendor_start;
      s1_vstop_r  <= in_vendor_stop;
      s1_dis_r    <= in_disable_request;
      s1_debug_r  <= in_debug_build;
      s1_boot_r   <= in_charger_boot;
      s1_sp_r     <= in_saved_present_secs;
      s1_sa_r     <= in_saved_active_secs;
    end
  end

  assign disabled = s1_dis_r || !s1_debug_r ||
                    (s1_vstart_r != dflt_start_r) || (s1_vstop_r != dflt_stop_r);
  assign act_th   = (act_after_r < MIN_ACTIVATE) ? CW'(MIN_ACTIVATE) : CW'(act_after_r);

  always_comb begin
    high_nxt    = high_r;
    present_nxt = present_r;
    absent_nxt  = absent_r;
    active_nxt  = active_r;

    // current state action
    unique case (state_r)
      ST_INIT: begin
        if (s1_power_r) begin
          present_nxt = sat_load(s1_sp_r);
          active_nxt  = sat_load(s1_sa_r);
        end
      end
      ST_DISABLED, ST_DISCONNECTED: begin
        high_nxt    = 1'b0;
        present_nxt = '0;
        absent_nxt  = '0;
        active_nxt  = '0;
      end
      ST_CONNECTED, ST_ACTIVE: begin
        if (s1_power_r) begin
          if (high_r) begin
            present_nxt = sat_add(present_r, s1_dt_r);
          end
          absent_nxt = '0;
        end else begin
          absent_nxt = sat_add(absent_r, s1_dt_r);
        end
        if (state_r == ST_ACTIVE) begin
          active_nxt = sat_add(active_r, s1_dt_r);
        end else if (s1_cap_r == full_cap_r) begin
          high_nxt = 1'b1;
        end
      end
      default: ;
    endcase

    // next state
    state_nxt = state_r;
    if (disabled) begin
      state_nxt = ST_DISABLED;
    end else begin
      unique case (state_r)
        ST_INIT: begin
          if (!s1_power_r) begin
            state_nxt = ST_DISCONNECTED;
          end else if (CW'(present_nxt) > act_th) begin
            state_nxt = ST_ACTIVE;
          end else begin
            state_nxt = ST_CONNECTED;
          end
        end
        ST_DISABLED: state_nxt = ST_DISCONNECTED;
        ST_DISCONNECTED: begin
          if (s1_power_r) begin
            state_nxt = ST_CONNECTED;
          end
        end
        ST_CONNECTED: begin
          if (CW'(present_nxt) > act_th) begin
            state_nxt = ST_ACTIVE;
          end else if (CW'(absent_nxt) > CW'(clr_after_r)) begin
            state_nxt = ST_DISCONNECTED;
          end
        end
        default: ;
      endcase
    end

    // entry action
    if (state_nxt != state_r) begin
      unique case (state_nxt)
        ST_DISABLED, ST_DISCONNECTED: begin
          high_nxt    = 1'b0;
          present_nxt = '0;
          absent_nxt  = '0;
          active_nxt  = '0;
        end
        ST_CONNECTED: begin
          if (present_nxt != '0) begin
            high_nxt = 1'b1;
          end
        end
        ST_ACTIVE: high_nxt = 1'b1;
        default: ;
      endcase
    end
  end

  assign lstart = (state_nxt == ST_ACTIVE) ? def_start_r : s1_vstart_r;
  assign lstop  = (state_nxt == ST_ACTIVE) ? def_stop_r  : s1_vstop_r;
  assign wstart = !s1_boot_r && (lstart != last_start_r);
  assign wstop  = !s1_boot_r && (lstop  != last_stop_r);

  cld_persist #(
    .TIME_BITS          (TIME_BITS),
    .PERSIST_HYSTERESIS (PERSIST_HYSTERESIS)
  ) u_present_persist (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (advance),
    .value  (present_nxt),
    .strobe (pp)
  );

  cld_persist #(
    .TIME_BITS          (TIME_BITS),
    .PERSIST_HYSTERESIS (PERSIST_HYSTERESIS)
  ) u_active_persist (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (advance),
    .value  (active_nxt),
    .strobe (ap)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_INIT;
      high_r       <= 1'b0;
      present_r    <= '0;
      absent_r     <= '0;
      active_r     <= '0;
      last_start_r <= RST_DEFAULT_START;
      last_stop_r  <= RST_DEFAULT_STOP;
    end else if (advance) begin
      state_r   <= state_nxt;
      high_r    <= high_nxt;
      present_r <= present_nxt;
      absent_r  <= absent_nxt;
      active_r  <= active_nxt;
      if (wstart) begin
        last_start_r <= lstart;
      end
      if (wstop) begin
        last_stop_r <= lstop;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_fsm_state       <= state_nxt;
      out_start_level     <= lstart;
      out_stop_level      <= lstop;
      out_start_write     <= wstart;
      out_stop_write      <= wstop;
      out_present_secs    <= SECS_W'(present_nxt);
      out_active_secs     <= SECS_W'(active_nxt);
      out_present_persist <= pp;
      out_active_persist  <= ap;
    end
  end

endmodule

>>> design/cld_persist.sv
`timescale 1ns / 1ps

module cld_persist #(
  parameter int unsigned TIME_BITS          = 31,
  parameter int unsigned PERSIST_HYSTERESIS = 30
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic [TIME_BITS-1:0] value,
  output logic                 strobe
);

  localparam int unsigned HW = $clog2(PERSIST_HYSTERESIS + 1) + 1;
  localparam int unsigned PW = TIME_BITS + HW;
  localparam logic [PW-1:0] HYST = PW'(PERSIST_HYSTERESIS);

  logic                 valid_r;
  logic [TIME_BITS-1:0] prev_r;
  logic [PW-1:0]        value_x;
  logic [PW-1:0]        prev_x;
  logic                 same;
  logic                 big;

  assign value_x = PW'(value);
  assign prev_x  = PW'(prev_r);
  assign same    = valid_r && (value == prev_r);
  assign big     = !valid_r || (value == '0) || (value_x > prev_x + HYST) ||
                   (value_x + HYST < prev_x);
  assign strobe  = !same && big;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en && strobe) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en && strobe) begin
      prev_r <= value;
    end
  end

endmodule
